>>> hdl/t1d_pkg.sv
// Shared types and constants for the Type I timing decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package t1d_pkg;

  // Divider geometry: one cell per quotient bit
  localparam int unsigned NUM_W = 38;  // dividend / quotient width
  localparam int unsigned DIV_W = 35;  // divisor / remainder width
  localparam int unsigned NUM_CELLS = NUM_W;

  localparam logic [NUM_W-1:0] PERIOD_NUMERATOR = NUM_W'(100000000);
  localparam logic [13:0] CLOCK_UNIT_HZ = 14'd10000;

  // Configuration register indexes and reset values
  localparam logic [7:0] REG_ASPECT_FOUR_THREE = 8'd0;
  localparam logic [7:0] REG_ASPECT_SIXTEEN_NINE = 8'd1;
  localparam logic [2:0] ASPECT_FOUR_THREE_RST = 3'd2;
  localparam logic [2:0] ASPECT_SIXTEEN_NINE_RST = 3'd4;

  // One divider lane in flight
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [NUM_W-1:0] num;  // dividend bits shift out, quotient bits shift in
    logic [DIV_W-1:0] div;
  } lane_t;

  // Fields that need no division, carried alongside
  typedef struct packed {
    logic [16:0] h_active;
    logic [17:0] v_active;
    logic [17:0] h_back_porch;
    logic [16:0] h_front_porch;
    logic [16:0] h_sync_width;
    logic [18:0] v_back_porch;
    logic [17:0] v_front_porch;
    logic [17:0] v_sync_width;
    logic [4:0]  mode_flags;
  } side_t;

  typedef struct packed {
    lane_t period;
    lane_t refresh;
    side_t side;
  } stage_t;

endpackage
`default_nettype wire

>>> hdl/t1d_front.sv
// Front stage: decodes the descriptor codes, forms the divider operands.
// Depends on t1d_pkg.
`default_nettype none
module t1d_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [23:0]            pixel_clock_code,
  input  wire logic [15:0]            h_active_code,
  input  wire logic [15:0]            h_blank_code,
  input  wire logic [15:0]            h_front_code,
  input  wire logic [15:0]            h_sync_code,
  input  wire logic [15:0]            v_active_code,
  input  wire logic [15:0]            v_blank_code,
  input  wire logic [15:0]            v_front_code,
  input  wire logic [15:0]            v_sync_code,
  input  wire logic [1:0]             sync_sense,
  input  wire logic                   interlaced,
  input  wire logic [2:0]             aspect_code,
  input  wire logic [2:0]             aspect_four_three,
  input  wire logic [2:0]             aspect_sixteen_nine,
  output logic                        out_valid,
  output t1d_pkg::stage_t             out_stage
);
  import t1d_pkg::*;

  logic [24:0] clk_units;
  logic [16:0] hact, hblank, hfront, hsync;
  logic [16:0] vact, vblank, vfront, vsync;
  logic [17:0] h_total, v_total;
  logic [38:0] pix_hz;
  logic [35:0] frame;
  logic [18:0] vback;
  logic        aspect43, aspect169;
  stage_t      stage_next;

  // Add one to every code, then form the totals, the two products, the vertical back porch and the aspect flags
  always_comb begin
    clk_units = {1'b0, pixel_clock_code} + 25'd1;
    hact   = {1'b0, h_active_code} + 17'd1;
    hblank = {1'b0, h_blank_code} + 17'd1;
    hfront = {1'b0, h_front_code} + 17'd1;
    hsync  = {1'b0, h_sync_code} + 17'd1;
    vact   = {1'b0, v_active_code} + 17'd1;
    vblank = {1'b0, v_blank_code} + 17'd1;
    vfront = {1'b0, v_front_code} + 17'd1;
    vsync  = {1'b0, v_sync_code} + 17'd1;
    h_total = {1'b0, hact} + {1'b0, hblank};
    v_total = {1'b0, vact} + {1'b0, vblank};
    pix_hz = {14'd0, clk_units} * {25'd0, CLOCK_UNIT_HZ};
    frame  = {18'd0, h_total} * {18'd0, v_total};
    vback  = {2'b00, vblank} - {2'b00, vfront} - {2'b00, vsync};
    aspect43  = (aspect_code == aspect_four_three);
    aspect169 = !aspect43 && (aspect_code == aspect_sixteen_nine);
  end

  // Build the operands and the side fields
  always_comb begin
    stage_next.period.rem  = '0;
    stage_next.period.num  = PERIOD_NUMERATOR;
    stage_next.period.div  = {10'd0, clk_units};
    stage_next.refresh.rem = '0;
    stage_next.refresh.num = pix_hz[NUM_W-1:0];
    stage_next.refresh.div = frame[DIV_W-1:0];
    stage_next.side.h_active      = hact;
    stage_next.side.h_back_porch  = {1'b0, hblank} - {1'b0, hfront} - {1'b0, hsync};
    stage_next.side.h_front_porch = hfront;
    stage_next.side.h_sync_width  = hsync;
    stage_next.side.mode_flags    = {aspect169, aspect43, interlaced, sync_sense};
    if (interlaced) begin
      stage_next.side.v_active      = {vact, 1'b0};
      stage_next.side.v_back_porch  = {vback[17:0], 1'b0};
      stage_next.side.v_front_porch = {vfront, 1'b0};
      stage_next.side.v_sync_width  = {vsync, 1'b0};
    end else begin
      stage_next.side.v_active      = {1'b0, vact};
      stage_next.side.v_back_porch  = vback;
      stage_next.side.v_front_porch = {1'b0, vfront};
      stage_next.side.v_sync_width  = {1'b0, vsync};
    end
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/t1d_cell.sv
// Divider cell: one restoring quotient bit for both divider lanes.
// Depends on t1d_pkg.
`default_nettype none
module t1d_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  t1d_pkg::stage_t       in_stage,
  output logic                  out_valid,
  output t1d_pkg::stage_t       out_stage
);
  import t1d_pkg::*;

  function automatic lane_t lane_step(input lane_t l);
    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    lane_t          r;
    shifted = {l.rem, l.num[NUM_W-1]};
    diff    = shifted - {1'b0, l.div};
    r.div   = l.div;
    if (shifted >= {1'b0, l.div}) begin
      r.rem = diff[DIV_W-1:0];
      r.num = {l.num[NUM_W-2:0], 1'b1};
    end else begin
      r.rem = shifted[DIV_W-1:0];
      r.num = {l.num[NUM_W-2:0], 1'b0};
    end
    return r;
  endfunction

  stage_t stage_next;

  always_comb begin
    stage_next.period  = lane_step(in_stage.period);
    stage_next.refresh = lane_step(in_stage.refresh);
    stage_next.side    = in_stage.side;
  end

  // Hand the transaction to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/displayid_type1_timing_decoder_unit.sv
// DisplayID Type I timing decoder: one descriptor in, one decoded mode out.
// Takes a new descriptor every cycle unless the output stalls; it has one front
// stage with the two multipliers, then a chain of 38 divider cells, one quotient
// bit each. The whole chain advances when the result register is empty or
// being taken, so a stalled output holds every stage. Configuration writes
// are always accepted. Depends on t1d_pkg, t1d_front, t1d_cell.
`default_nettype none
module displayid_type1_timing_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] pixel_clock_code,
  input  wire logic [15:0] h_active_code,
  input  wire logic [15:0] h_blank_code,
  input  wire logic [15:0] h_front_code,
  input  wire logic [15:0] h_sync_code,
  input  wire logic [15:0] v_active_code,
  input  wire logic [15:0] v_blank_code,
  input  wire logic [15:0] v_front_code,
  input  wire logic [15:0] v_sync_code,
  input  wire logic [1:0]  sync_sense,
  input  wire logic        interlaced,
  input  wire logic [2:0]  aspect_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [26:0]      pixel_period_ps,
  output logic [35:0]      refresh_hz,
  output logic [16:0]      h_active,
  output logic [17:0]      v_active,
  output logic [17:0]      h_back_porch,
  output logic [16:0]      h_front_porch,
  output logic [16:0]      h_sync_width,
  output logic [18:0]      v_back_porch,
  output logic [17:0]      v_front_porch,
  output logic [17:0]      v_sync_width,
  output logic [4:0]       mode_flags
);
  import t1d_pkg::*;

  logic       en;
  logic [2:0] aspect_four_three;
  logic [2:0] aspect_sixteen_nine;
  logic       valid [NUM_CELLS+1];
  stage_t     stage [NUM_CELLS+1];

  // Advance the whole chain unless the result waits
  assign en        = !valid[NUM_CELLS] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      aspect_four_three   <= ASPECT_FOUR_THREE_RST;
      aspect_sixteen_nine <= ASPECT_SIXTEEN_NINE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ASPECT_FOUR_THREE) begin
        aspect_four_three <= cfg_data[2:0];
      end else if (cfg_index == REG_ASPECT_SIXTEEN_NINE) begin
        aspect_sixteen_nine <= cfg_data[2:0];
      end
    end
  end

  t1d_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .en                  (en),
    .in_valid            (in_valid),
    .pixel_clock_code    (pixel_clock_code),
    .h_active_code       (h_active_code),
    .h_blank_code        (h_blank_code),
    .h_front_code        (h_front_code),
    .h_sync_code         (h_sync_code),
    .v_active_code       (v_active_code),
    .v_blank_code        (v_blank_code),
    .v_front_code        (v_front_code),
    .v_sync_code         (v_sync_code),
    .sync_sense          (sync_sense),
    .interlaced          (interlaced),
    .aspect_code         (aspect_code),
    .aspect_four_three   (aspect_four_three),
    .aspect_sixteen_nine (aspect_sixteen_nine),
    .out_valid           (valid[0]),
    .out_stage           (stage[0])
  );

  // Divider chain
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    t1d_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (valid[i]),
      .in_stage  (stage[i]),
      .out_valid (valid[i+1]),
      .out_stage (stage[i+1])
    );
  end

  // Last cell is the result register
  assign out_valid       = valid[NUM_CELLS];
  assign pixel_period_ps = stage[NUM_CELLS].period.num[26:0];
  assign refresh_hz      = stage[NUM_CELLS].refresh.num[35:0];
  assign h_active        = stage[NUM_CELLS].side.h_active;
  assign v_active        = stage[NUM_CELLS].side.v_active;
  assign h_back_porch    = stage[NUM_CELLS].side.h_back_porch;
  assign h_front_porch   = stage[NUM_CELLS].side.h_front_porch;
  assign h_sync_width    = stage[NUM_CELLS].side.h_sync_width;
  assign v_back_porch    = stage[NUM_CELLS].side.v_back_porch;
  assign v_front_porch   = stage[NUM_CELLS].side.v_front_porch;
  assign v_sync_width    = stage[NUM_CELLS].side.v_sync_width;
  assign mode_flags      = stage[NUM_CELLS].side.mode_flags;

endmodule
`default_nettype wire
